### hw/rtl/tcpq_pkg.sv
// types, codes and defaults shared by the three-class priority queue
`default_nettype none

package tcpq_pkg;

   localparam int CLASS_DEPTH_DEFAULT  = 16;
   localparam int HANDLE_WIDTH_DEFAULT = 32;
   localparam int NUM_CLASSES          = 3;

   localparam int HANDLE_FIELD_W    = 32;
   localparam int OCCUPANCY_W       = 6;
   localparam int THRESHOLD_W       = 6;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 6'd48;

   typedef enum logic [1:0] {
      CMD_PUSH         = 2'd0,
      CMD_POP_ANY      = 2'd1,
      CMD_POP_INTERNAL = 2'd2,
      CMD_STATUS       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CLS_INTERNAL = 2'd0,
      CLS_URGENT   = 2'd1,
      CLS_REGULAR  = 2'd2
   } queue_class_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic                      internal_flag;
      logic                      urgent_flag;
      logic [HANDLE_FIELD_W-1:0] message_handle;
   } req_type;

   typedef struct packed {
      logic                      popped_valid;
      logic [HANDLE_FIELD_W-1:0] popped_handle;
      queue_class_type           popped_class;
      logic                      push_dropped;
      logic [OCCUPANCY_W-1:0]    occupancy;
      logic                      full_res;
      logic                      half_full;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/tcpq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module tcpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/three_class_priority_queue_unit.sv
// three-class strict-priority message queue, top level
//
// requests arrive on req_valid / req_ready with a req_payload of command,
// class flags and message handle; one response per request leaves on
// rsp_valid / rsp_ready with popped handle, class, drop flag and occupancy
// a push files the handle into internal, urgent or regular class by its
// flags; a pop takes the oldest handle of the highest non-empty class, a
// pop-internal only from internal; one shared ram holds all handles, one
// region of CLASS_DEPTH words per class; head, tail and count are flip-flops
// latency: push, status and a pop that finds nothing answer in the cycle after
// acceptance; a pop that finds a handle answers once the registered ram read
// has passed through ST_READ
// throughput: push and status 1 request per cycle while responses are taken;
// a successful pop holds req_ready low in ST_READ, set by the single ram port
// csr_write_enable writes the threshold register at once, with no handshake
// reset: synchronous; queue empty, threshold 48, no response pending;
// the ram contents are not cleared, so no clearing pass is needed
// when the receiver stalls the response is held in the output register
// and req_ready stays low until it is taken
`default_nettype none

module three_class_priority_queue_unit #(
   parameter int CLASS_DEPTH  = tcpq_pkg::CLASS_DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = tcpq_pkg::HANDLE_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire tcpq_pkg::req_type                   req_payload,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output tcpq_pkg::rsp_type                        rsp_payload,
   // threshold register
   input  wire logic                                csr_write_enable,
   input  wire logic [tcpq_pkg::THRESHOLD_W-1:0]    csr_write_data
);

   import tcpq_pkg::*;

   localparam int PTR_W  = $clog2(CLASS_DEPTH);
   localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
   localparam int RAM_DEPTH = NUM_CLASSES * CLASS_DEPTH;
   localparam int ADDR_W = $clog2(RAM_DEPTH);
   localparam int TOT_W  = $clog2(RAM_DEPTH + 1);
   localparam int CMP_W  = (TOT_W > THRESHOLD_W) ? TOT_W : THRESHOLD_W;

   // per-class bookkeeping
   logic [PTR_W-1:0] head_ff [NUM_CLASSES];
   logic [PTR_W-1:0] head_in [NUM_CLASSES];
   logic [PTR_W-1:0] tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0] tail_in [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] count_in [NUM_CLASSES];

   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [THRESHOLD_W-1:0] threshold_in;

   state_type state_ff;
   state_type state_in;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic            accept;
   logic            is_push;
   logic            is_pop;
   queue_class_type push_cls;
   queue_class_type pop_cls;
   logic            pop_hit;
   logic            push_full;
   logic [TOT_W-1:0] total;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [HANDLE_WIDTH-1:0] ram_wr_data;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [HANDLE_WIDTH-1:0] ram_rd_data;

   // class region base plus pointer
   function automatic logic [ADDR_W-1:0] ram_addr(queue_class_type cls,
                                                  logic [PTR_W-1:0] ptr);
      logic [ADDR_W-1:0] addr;
      case (cls)
         CLS_INTERNAL: addr = ADDR_W'(ptr);
         CLS_URGENT:   addr = ADDR_W'(CLASS_DEPTH) + ADDR_W'(ptr);
         CLS_REGULAR:  addr = ADDR_W'(2 * CLASS_DEPTH) + ADDR_W'(ptr);
         default:      addr = '0;
      endcase
      return addr;
   endfunction

   function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(CLASS_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign accept  = req_valid && req_ready;
   assign is_push = (req_payload.cmd == CMD_PUSH);
   assign is_pop  = (req_payload.cmd == CMD_POP_ANY) ||
                    (req_payload.cmd == CMD_POP_INTERNAL);

   // class selection for push and pop
   always_comb begin
      if (req_payload.internal_flag) begin
         push_cls = CLS_INTERNAL;
      end else if (req_payload.urgent_flag) begin
         push_cls = CLS_URGENT;
      end else begin
         push_cls = CLS_REGULAR;
      end

      pop_hit = 1'b1;
      if (count_ff[CLS_INTERNAL] != '0) begin
         pop_cls = CLS_INTERNAL;
      end else if (req_payload.cmd == CMD_POP_ANY && count_ff[CLS_URGENT] != '0) begin
         pop_cls = CLS_URGENT;
      end else if (req_payload.cmd == CMD_POP_ANY && count_ff[CLS_REGULAR] != '0) begin
         pop_cls = CLS_REGULAR;
      end else begin
         pop_cls = CLS_INTERNAL;
         pop_hit = 1'b0;
      end
      pop_hit = pop_hit && is_pop;
   end

   assign push_full = (count_ff[push_cls] == CNT_W'(CLASS_DEPTH));

   // pointer and count update, ram access
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ram_addr(push_cls, tail_ff[push_cls]);
      ram_wr_data = HANDLE_WIDTH'(req_payload.message_handle);
      ram_rd_addr = ram_addr(pop_cls, head_ff[pop_cls]);
      if (accept && is_push && !push_full) begin
         ram_wr_en          = 1'b1;
         tail_in[push_cls]  = advance(tail_ff[push_cls]);
         count_in[push_cls] = count_ff[push_cls] + 1'b1;
      end
      if (accept && pop_hit) begin
         head_in[pop_cls]  = advance(head_ff[pop_cls]);
         count_in[pop_cls] = count_ff[pop_cls] - 1'b1;
      end
   end

   // occupancy after this request
   assign total = TOT_W'(count_in[CLS_INTERNAL]) + TOT_W'(count_in[CLS_URGENT]) +
                  TOT_W'(count_in[CLS_REGULAR]);

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         threshold_in = csr_write_data;
      end
   end

   // response register; a successful pop fills in the handle during ST_READ, the cycle after the other fields
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (state_ff == ST_READ) begin
         rsp_valid_in         = 1'b1;
         rsp_in.popped_handle = HANDLE_FIELD_W'(ram_rd_data);
      end else if (accept) begin
         rsp_valid_in         = !pop_hit;
         rsp_in.popped_valid  = pop_hit;
         rsp_in.popped_handle = '0;
         rsp_in.popped_class  = pop_hit ? pop_cls : CLS_INTERNAL;
         rsp_in.push_dropped  = is_push && push_full;
         rsp_in.occupancy     = OCCUPANCY_W'(total);
         rsp_in.full_res      = (CMP_W'(total) >= CMP_W'(threshold_ff));
         rsp_in.half_full     = (CMP_W'(total) >= CMP_W'(threshold_ff >> 1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && pop_hit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: req_ready = !rsp_valid_ff || rsp_ready;
         ST_READ: req_ready = 1'b0;
         default: req_ready = 1'b0;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   tcpq_ram #(
      .WIDTH (HANDLE_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef ASSERT_OFF
   // no class ever holds more than its region
   assert property (@(posedge clock) disable iff (reset)
      count_ff[CLS_INTERNAL] <= CNT_W'(CLASS_DEPTH) &&
      count_ff[CLS_URGENT] <= CNT_W'(CLASS_DEPTH) &&
      count_ff[CLS_REGULAR] <= CNT_W'(CLASS_DEPTH))
      else $error("class count beyond depth");

   // output slot is free while the ram read is in flight
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("response pending during ram read");

   // a successful pop goes through the read cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && pop_hit |=> state_ff == ST_READ && !req_ready)
      else $error("pop did not wait for ram data");

   // an empty answer carries zero handle and class
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.popped_valid |->
         rsp_ff.popped_handle == '0 && rsp_ff.popped_class == CLS_INTERNAL)
      else $error("empty response carries data");
`endif

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// testbench for the three-class priority queue, checked against a predictor
module tb;
   import tcpq_pkg::*;

   localparam int RING_DEPTH  = CLASS_DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 1000;   // cycles with no handshake on either side
   localparam int SETTLE      = 4;      // margin kept after the last response is taken
   localparam int PRED_DEPTH  = 8;      // at most two responses are ever outstanding

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_type                req_payload      = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write_enable = 1'b0;
   logic [THRESHOLD_W-1:0] csr_write_data   = '0;

   // predictor state: one ring of handles per class plus the threshold copy
   logic [HANDLE_FIELD_W-1:0] class_ring [NUM_CLASSES][RING_DEPTH];
   int                        ring_head  [NUM_CLASSES];
   int                        ring_count [NUM_CLASSES];
   logic [THRESHOLD_W-1:0]    threshold_model;

   // responses predicted for accepted requests, oldest first
   rsp_type predicted_ring [PRED_DEPTH];
   int      pred_wr_count   = 0;
   int      pred_rd_count   = 0;
   int      mismatch_count  = 0;

   // idling controls, changed by the test tasks
   bit sender_idling   = 1'b1;
   bit receiver_idling = 1'b1;
   int hold_off_cycles = 0;

   three_class_priority_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // number of predicted responses not yet taken
   function automatic int outstanding_responses();
      return pred_wr_count - pred_rd_count;
   endfunction

   // works out the response to one request and moves the predicted queue state on
   function automatic rsp_type predict_response(input req_type r);
      rsp_type         e;
      queue_class_type cls;
      bit              found;
      int              total;
      e     = '0;
      found = 1'b0;
      cls   = CLS_REGULAR;
      case (r.cmd)
         CMD_PUSH: begin
            // internal wins over urgent when both flags are set
            if (r.internal_flag)
               cls = CLS_INTERNAL;
            else if (r.urgent_flag)
               cls = CLS_URGENT;
            if (ring_count[cls] == RING_DEPTH) begin
               // class full: handle discarded, nothing moves
               e.push_dropped = 1'b1;
            end else begin
               class_ring[cls][(ring_head[cls] + ring_count[cls]) % RING_DEPTH] =
                  r.message_handle;
               ring_count[cls]++;
            end
         end
         CMD_POP_ANY, CMD_POP_INTERNAL: begin
            // strict priority; pop-internal never looks past the internal class
            if (ring_count[CLS_INTERNAL] > 0) begin
               cls   = CLS_INTERNAL;
               found = 1'b1;
            end else if (r.cmd == CMD_POP_ANY && ring_count[CLS_URGENT] > 0) begin
               cls   = CLS_URGENT;
               found = 1'b1;
            end else if (r.cmd == CMD_POP_ANY && ring_count[CLS_REGULAR] > 0) begin
               cls   = CLS_REGULAR;
               found = 1'b1;
            end
            if (found) begin
               e.popped_valid  = 1'b1;
               e.popped_handle = class_ring[cls][ring_head[cls]];
               e.popped_class  = cls;
               ring_head[cls]  = (ring_head[cls] + 1) % RING_DEPTH;
               ring_count[cls]--;
            end
         end
         default: ;   // status only: state untouched
      endcase
      total = ring_count[CLS_INTERNAL] + ring_count[CLS_URGENT] + ring_count[CLS_REGULAR];
      e.occupancy = OCCUPANCY_W'(total);
      // flags compare the true total; a zero threshold makes both always set
      e.full_res  = (total >= int'(threshold_model));
      e.half_full = (total >= int'(threshold_model >> 1));
      return e;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // matches one accepted response against the oldest prediction
   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (outstanding_responses() == 0) begin
         $error("response with no request outstanding, handle %h", got.popped_handle);
         mismatch_count++;
         return;
      end
      want = predicted_ring[pred_rd_count % PRED_DEPTH];
      pred_rd_count++;
      compare_field("popped_valid",  32'(want.popped_valid),  32'(got.popped_valid));
      compare_field("popped_handle", 32'(want.popped_handle), 32'(got.popped_handle));
      compare_field("popped_class",  32'(want.popped_class),  32'(got.popped_class));
      compare_field("push_dropped",  32'(want.push_dropped),  32'(got.push_dropped));
      compare_field("occupancy",     32'(want.occupancy),     32'(got.occupancy));
      compare_field("full_res",      32'(want.full_res),      32'(got.full_res));
      compare_field("half_full",     32'(want.half_full),     32'(got.half_full));
   endtask

   // response side: checks what was taken at this edge, then picks the next rsp_ready
   initial begin : response_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            check_response(rsp_payload);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_off_cycles > 0) begin
            // long hold-off so the queue backs up and stalls its input
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = int'($urandom_range(1, 7)) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: ends the run if neither side moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type make_request(input cmd_type cmd, input logic internal_flag,
                                            input logic urgent_flag, input logic [31:0] handle);
      req_type r;
      r.cmd            = cmd;
      r.internal_flag  = internal_flag;
      r.urgent_flag    = urgent_flag;
      r.message_handle = handle;
      return r;
   endfunction

   // push_percent sets the push share; the rest spread over the other commands
   function automatic req_type random_request(input int push_percent);
      cmd_type cmd;
      if (int'($urandom_range(0, 99)) < push_percent)
         cmd = CMD_PUSH;
      else
         cmd = cmd_type'(2'($urandom_range(1, 3)));
      return make_request(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom());
   endfunction

   // offers one request, holds it until taken, then records its prediction;
   // valid is left high so a following request goes out back to back
   task automatic send_request(input req_type r);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      if (outstanding_responses() >= PRED_DEPTH) begin
         $error("prediction ring overflow");
         mismatch_count++;
      end
      predicted_ring[pred_wr_count % PRED_DEPTH] = predict_response(r);
      pred_wr_count++;
   endtask

   // stops offering and waits for every outstanding response, plus the latency
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (outstanding_responses() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // only called with the queue idle
   task automatic write_threshold(input logic [THRESHOLD_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      threshold_model  = value;
   endtask

   task automatic send_random_block(input int count, input int push_percent);
      for (int i = 0; i < count; i++)
         send_request(random_request(push_percent));
   endtask

   // every command, handle extremes, priority order and the empty-selection cases
   task automatic test_directed();
      send_request(make_request(CMD_STATUS,       1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_POP_ANY,      1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_POP_INTERNAL, 1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_PUSH,         1'b0, 1'b1, 32'hFFFF_FFFF));
      send_request(make_request(CMD_PUSH,         1'b0, 1'b0, 32'h0000_0000));
      // internal-only pop must ignore the urgent and regular handles
      send_request(make_request(CMD_POP_INTERNAL, 1'b1, 1'b1, 32'hFFFF_FFFF));
      send_request(make_request(CMD_PUSH,         1'b1, 1'b1, 32'h8000_0001));
      send_request(make_request(CMD_PUSH,         1'b1, 1'b0, 32'h7FFF_FFFE));
      send_request(make_request(CMD_PUSH,         1'b0, 1'b1, 32'h5555_5555));
      send_request(make_request(CMD_PUSH,         1'b0, 1'b0, 32'hAAAA_AAAA));
      send_request(make_request(CMD_STATUS,       1'b1, 1'b1, 32'hFFFF_FFFF));
      send_request(make_request(CMD_POP_INTERNAL, 1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_POP_ANY,      1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_POP_ANY,      1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_POP_ANY,      1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_POP_INTERNAL, 1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_POP_ANY,      1'b1, 1'b0, 32'h1234_5678));
      send_request(make_request(CMD_POP_ANY,      1'b0, 1'b1, 32'h0000_0000));
      send_request(make_request(CMD_POP_ANY,      1'b0, 1'b0, 32'h0000_0000));
      send_request(make_request(CMD_STATUS,       1'b0, 1'b0, 32'h0000_0000));
      wait_for_drain();
   endtask

   // fills every class past its depth so each drops a push, then empties the lot
   task automatic test_class_fill();
      for (int i = 0; i < RING_DEPTH + 1; i++) begin
         send_request(make_request(CMD_PUSH, 1'b1, 1'($urandom_range(0, 1)), $urandom()));
         send_request(make_request(CMD_PUSH, 1'b0, 1'b1, $urandom()));
         send_request(make_request(CMD_PUSH, 1'b0, 1'b0, $urandom()));
      end
      send_request(make_request(CMD_STATUS, 1'b0, 1'b0, $urandom()));
      for (int i = 0; i < NUM_CLASSES * RING_DEPTH + 4; i++)
         send_request(make_request(CMD_POP_ANY, 1'b0, 1'b0, $urandom()));
      wait_for_drain();
   endtask

   // threshold sweep: zero, one, two, half the capacity, the capacity and its neighbours, above capacity, random
   task automatic test_thresholds();
      logic [THRESHOLD_W-1:0] settings [9];
      settings = '{6'd0, 6'd1, 6'd63, 6'd49, 6'd48, 6'd47, 6'd24, 6'd2,
                   THRESHOLD_W'($urandom_range(0, 63))};
      foreach (settings[k]) begin
         wait_for_drain();
         write_threshold(settings[k]);
         send_random_block(60, 80);
         send_random_block(40, 25);
      end
      wait_for_drain();
      write_threshold(THRESHOLD_RESET);
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      wait_for_drain();
      hold_off_cycles = 150;
      sender_idling   = 1'b0;
      send_random_block(40, 70);
      sender_idling   = 1'b1;
      // sender pauses here until every response is back
      wait_for_drain();
   endtask

   // long random mix; the push share swings so the occupancy sweeps empty to full
   task automatic test_random_traffic();
      int push_shares [7];
      push_shares = '{80, 20, 60, 35, 90, 10, 50};
      foreach (push_shares[k])
         send_random_block(100, push_shares[k]);
      wait_for_drain();
   endtask

   // final stretch at full rate on both sides
   task automatic test_full_rate();
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      send_random_block(150, 65);
      send_random_block(100, 40);
      wait_for_drain();
   endtask

   initial begin : main
      foreach (ring_head[c]) begin
         ring_head[c]  = 0;
         ring_count[c] = 0;
      end
      threshold_model = THRESHOLD_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_class_fill();
      test_thresholds();
      test_backpressure();
      test_random_traffic();
      test_full_rate();

      if (mismatch_count == 0 && outstanding_responses() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
